// File: src/f2h_pkg.sv
// Package for the single-to-half precision converter.
// Holds the field constants and the conversion function; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package f2h_pkg;
	localparam logic [15:0] SIGN_BIT16 = 16'h8000;
	localparam logic [15:0] INF16 = 16'h7C00;
	localparam logic [7:0] BIAS32 = 8'd127;

	function automatic logic [15:0] convert_bits(input logic [31:0] x);
		logic [15:0] sgn;
		logic [7:0] ex;
		logic [23:0] m;
		logic [4:0] sh;
		logic [23:0] shifted;
		logic [15:0] r;
		sgn = {x[31], 15'd0};
		ex = x[30:23];
		m = {1'b1, x[22:0]};
		sh = 5'(8'd113 - ex);
		shifted = m >> sh;
		r = 16'd0;
		if (ex < 8'd103) begin
			r = sgn;
		end else if (ex > 8'd142) begin
			r = sgn | INF16;
		end else if (ex < 8'd113) begin
			r = sgn | {5'd0, shifted[23:13]} + {15'd0, shifted[12]};
		end else begin
			r = (sgn | {1'b0, 5'(ex - BIAS32 + 8'd15), x[22:13]}) + {15'd0, x[12]};
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// File: src/float32_to_float16_convert.sv
// Top level of the single-to-half precision converter.
// Depends on f2h_pkg for the conversion function.
`timescale 1ns / 1ps
`default_nettype none
// Converts one binary32 pattern per request into a binary16 pattern, rounding half up and
// mapping NaN to infinity. An accepted request goes into the input register. When the output
// advances, the rounding logic writes its result into the result register, which presents it.
// A new request is taken every cycle while the input is not stalled. The input
// stalls only while the output is stalled and both registers hold a request.
module float32_to_float16_convert (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic [31:0] single_bits,
	output logic out_valid,
	input wire logic out_stall,
	output logic [15:0] half_bits
);
	logic v_s1;
	logic [31:0] x_s1;
	logic adv_s1;
	logic adv_s2;

	assign adv_s2 = !out_valid || !out_stall;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) x_s1 <= single_bits;
		if (adv_s2 && v_s1) half_bits <= f2h_pkg::convert_bits(x_s1);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(half_bits))
		else $error("result changed while stalled");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && adv_s2 |=> out_valid)
		else $error("stage one request lost");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v_s1 && out_valid)
		else $error("stall without full pipeline");
endmodule
`default_nettype wire

// File: dv/tb_float32_to_float16_convert.sv
// Testbench for the single-to-half precision converter.
// Drives binary32 patterns with random gaps and stalls and checks each half result
// against an independent predictor; depends only on the block's top level.
`timescale 1ns / 1ps
module tb_float32_to_float16_convert;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [31:0] single_bits;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] half_bits;

	logic [15:0] expected_halves[$];
	int errors = 0;
	int cycles = 0;
	bit quiet_phase;

	localparam int CYCLE_LIMIT = 200000;

	float32_to_float16_convert u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.single_bits(single_bits),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.half_bits(half_bits)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [15:0] predict_half(input logic [31:0] x);
		logic [15:0] sgn;
		int unsigned ex;
		int e;
		logic [31:0] m;
		int sh;
		logic [31:0] r;
		sgn = x[31] ? 16'h8000 : 16'h0000;
		ex = {24'd0, x[30:23]};
		e = int'(ex) - 127;
		if (e < -24) return sgn;
		if (e > 15) return sgn | 16'h7C00;
		if (e < -14) begin
			m = {9'd0, x[22:0]} | 32'h0080_0000;
			sh = -e - 14;
			r = {16'd0, sgn} | (m >> (sh + 13));
			if (m[sh + 12]) r = r + 1;
			return r[15:0];
		end
		r = {16'd0, sgn} | (32'(e + 15) << 10) | ({9'd0, x[22:0]} >> 13);
		if (x[12]) r = r + 1;
		return r[15:0];
	endfunction

	task automatic send_single(input logic [31:0] x);
		if (!quiet_phase) begin
			while ($urandom_range(99) < 9) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		single_bits <= x;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_halves.push_back(predict_half(x));
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n) out_stall <= !quiet_phase && ($urandom_range(99) < 9);
		if (arst_n && out_valid && !out_stall) begin
			if (expected_halves.size() == 0) begin
				errors <= errors + 1;
				$display("%0t: unexpected result, expected none, actual %h", $time, half_bits);
			end else begin
				if (half_bits !== expected_halves[0]) begin
					errors <= errors + 1;
					$display("%0t: half_bits mismatch, expected %h, actual %h", $time,
						expected_halves[0], half_bits);
				end
				void'(expected_halves.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic test_special_values();
		send_single(32'h0000_0000);
		send_single(32'h8000_0000);
		send_single(32'h0000_0001);
		send_single(32'h807F_FFFF);
		send_single(32'h7F80_0000);
		send_single(32'hFF80_0000);
		send_single(32'h7FC0_0000);
		send_single(32'hFFFF_FFFF);
		send_single(32'h7F80_0001);
	endtask

	task automatic test_range_edges();
		send_single(32'h477F_E000);
		send_single(32'h477F_F000);
		send_single(32'hC77F_FFFF);
		send_single(32'h4780_0000);
		send_single(32'h3880_0000);
		send_single(32'h387F_F000);
		send_single(32'hB87F_FFFF);
		send_single(32'h3380_0000);
		send_single(32'h337F_FFFF);
		send_single(32'h3300_0000);
		send_single(32'h3F80_1000);
		send_single(32'h3F80_0FFF);
		send_single(32'hBF80_0000);
		send_single(32'h5555_5555);
		send_single(32'hAAAA_AAAA);
	endtask

	task automatic test_random_values();
		logic [31:0] x;
		for (int i = 0; i < 1100; i++) begin
			quiet_phase = (i >= 400 && i < 600);
			x = $urandom;
			if ($urandom_range(3) != 0) x[30:23] = 8'($urandom_range(142, 101));
			send_single(x);
		end
		quiet_phase = 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		single_bits = 32'd0;
		quiet_phase = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_special_values();
		test_range_edges();
		test_random_values();
		in_valid <= 1'b0;
		while (expected_halves.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule

// File: sim.f
src/f2h_pkg.sv
src/float32_to_float16_convert.sv
dv/tb_float32_to_float16_convert.sv
